// File: design/tcl_pkg.sv
`default_nettype none

package tcl_pkg;

    localparam int unsigned COL_W   = 6;
    localparam int unsigned PC_W    = 4;
    localparam int unsigned ROM_LEN = 16;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LEAD  = 8'hC3;
    localparam logic [7:0] CH_TRAIL = 8'h87;
    localparam logic [7:0] CH_CCED  = 8'hC7;
    localparam logic [7:0] CMD_ROW1 = 8'h80;
    localparam logic [7:0] CMD_ROW2 = 8'hC0;
    localparam logic [COL_W-1:0] COL_MAX = 6'd63;

    // Write (or side effect) issued by one microcode step.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_PUT_B,
        OP_COPY,
        OP_SPACE,
        OP_PUT_C3,
        OP_PUT_C7,
        OP_CMD_80,
        OP_CMD_C0,
        OP_CR,
        OP_SET_PEND
    } t_op;

    // Branch condition of one microcode step.
    typedef enum logic [3:0] {
        CND_NEVER,
        CND_ALWAYS,
        CND_PEND,
        CND_IS_C3,
        CND_IS_CR,
        CND_IS_LF,
        CND_NOT_ROW2,
        CND_IS_87,
        CND_IDX_MORE
    } t_cond;

    typedef struct packed {
        t_op            op;
        t_cond          cond;
        logic [PC_W-1:0] target;
        logic           fin;
    } t_uword;

    // Microcode program. A taken branch loads target, otherwise the step
    // counter advances by one. The fin bit closes the transaction.
    function automatic t_uword rom_word(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '{op: OP_NONE, cond: CND_NEVER, target: 4'd0, fin: 1'b0};
        case (pc)
            4'd0:  w = '{op: OP_NONE,     cond: CND_PEND,     target: 4'd12, fin: 1'b0};
            4'd1:  w = '{op: OP_NONE,     cond: CND_IS_C3,    target: 4'd11, fin: 1'b0};
            4'd2:  w = '{op: OP_NONE,     cond: CND_IS_CR,    target: 4'd15, fin: 1'b0};
            4'd3:  w = '{op: OP_NONE,     cond: CND_IS_LF,    target: 4'd5,  fin: 1'b0};
            4'd4:  w = '{op: OP_PUT_B,    cond: CND_NEVER,    target: 4'd0,  fin: 1'b1};
            4'd5:  w = '{op: OP_NONE,     cond: CND_NOT_ROW2, target: 4'd8,  fin: 1'b0};
            4'd6:  w = '{op: OP_CMD_80,   cond: CND_NEVER,    target: 4'd0,  fin: 1'b0};
            4'd7:  w = '{op: OP_COPY,     cond: CND_IDX_MORE, target: 4'd7,  fin: 1'b0};
            4'd8:  w = '{op: OP_CMD_C0,   cond: CND_NEVER,    target: 4'd0,  fin: 1'b0};
            4'd9:  w = '{op: OP_SPACE,    cond: CND_IDX_MORE, target: 4'd9,  fin: 1'b0};
            4'd10: w = '{op: OP_CMD_C0,   cond: CND_NEVER,    target: 4'd0,  fin: 1'b1};
            4'd11: w = '{op: OP_SET_PEND, cond: CND_NEVER,    target: 4'd0,  fin: 1'b1};
            4'd12: w = '{op: OP_NONE,     cond: CND_IS_87,    target: 4'd14, fin: 1'b0};
            4'd13: w = '{op: OP_PUT_C3,   cond: CND_ALWAYS,   target: 4'd1,  fin: 1'b0};
            4'd14: w = '{op: OP_PUT_C7,   cond: CND_NEVER,    target: 4'd0,  fin: 1'b1};
            4'd15: w = '{op: OP_CR,       cond: CND_NEVER,    target: 4'd0,  fin: 1'b1};
            default: w = '{op: OP_NONE,   cond: CND_NEVER,    target: 4'd0,  fin: 1'b1};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: design/text_to_char_lcd_writes.sv
`default_nettype none

// Channel    | Direction | Handshake                     | Payload
// -----------+-----------+-------------------------------+-------------------------------
// char in    | input     | i_char_valid / o_char_ready   | i_char_byte
// result out | output    | o_res_valid / i_res_ready     | o_first_*, o_second_*, o_last
//
// One text byte is taken per transaction and worked off by a 16-step
// microcode program, one step per cycle; each step issues at most one
// display write, and writes are paired into results.
// How long a byte runs depends on its kind: a line feed runs one row loop of
// the program on row one and both row loops on row two, and a pending lead
// byte not followed by its trail byte is written out before the new byte is
// worked off. The next byte is taken the cycle after the last step.
// Reset is synchronous; the stored row-two copy reads as spaces through
// per-entry valid bits, so no clearing pass follows reset.
// A step waits while a result is held and not taken; no new byte is taken
// until the program for the current byte has finished.
module text_to_char_lcd_writes
    import tcl_pkg::*;
#(
    parameter int unsigned ROW_WIDTH = 40
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_char_valid,
    output logic            o_char_ready,
    input  wire logic [7:0] i_char_byte,
    output logic            o_res_valid,
    input  wire logic       i_res_ready,
    output logic            o_first_is_data,
    output logic [7:0]      o_first_byte,
    output logic            o_second_valid,
    output logic            o_second_is_data,
    output logic [7:0]      o_second_byte,
    output logic            o_last
);

    localparam int unsigned AW = $clog2(ROW_WIDTH);
    localparam logic [AW-1:0] IDX_LAST = AW'(ROW_WIDTH - 1);
    localparam logic [COL_W-1:0] COL_LIMIT = COL_W'(ROW_WIDTH);

    // Sequencer state.
    logic            r_busy;
    logic [PC_W-1:0] r_pc;
    logic [7:0]      r_byte;
    logic [AW-1:0]   r_idx;

    // Terminal state.
    logic            r_row2;
    logic [COL_W-1:0] r_col;
    logic            r_pend;

    // Row-two copy: memory with registered read, plus valid bits so that
    // entries never written read as spaces.
    logic [7:0]          r_mem [ROW_WIDTH];
    logic [ROW_WIDTH-1:0] r_mem_vld;
    logic [7:0]          r_rd_data;
    logic                r_rd_vld;

    // Write pairing: the first write of a pair waits here.
    logic       r_half_vld;
    logic       r_half_rs;
    logic [7:0] r_half_byte;

    logic       r_out_vld;

    t_uword          uw;
    logic            go;
    logic            taken;
    logic [PC_W-1:0] n_pc;
    logic [AW-1:0]   n_idx;
    logic [AW-1:0]   rd_addr;
    logic            emit;
    logic            w_rs;
    logic [7:0]      w_byte;
    logic            is_put;
    logic            do_store;
    logic            produce;

    assign uw           = rom_word(r_pc);
    assign go           = r_busy && (!r_out_vld || i_res_ready);
    assign o_char_ready = !r_busy;
    assign o_res_valid  = r_out_vld;

    always_comb begin
        case (uw.cond)
            CND_NEVER:    taken = 1'b0;
            CND_ALWAYS:   taken = 1'b1;
            CND_PEND:     taken = r_pend;
            CND_IS_C3:    taken = (r_byte == CH_LEAD);
            CND_IS_CR:    taken = (r_byte == CH_CR);
            CND_IS_LF:    taken = (r_byte == CH_LF);
            CND_NOT_ROW2: taken = !r_row2;
            CND_IS_87:    taken = (r_byte == CH_TRAIL);
            CND_IDX_MORE: taken = (r_idx != IDX_LAST);
            default:      taken = 1'b0;
        endcase
        n_pc = taken ? uw.target : r_pc + 1'b1;
    end

    // Datapath controlled by the current control word.
    always_comb begin
        emit   = 1'b1;
        w_rs   = 1'b1;
        w_byte = r_byte;
        is_put = 1'b0;
        case (uw.op)
            OP_PUT_B: begin
                is_put = 1'b1;
            end
            OP_COPY: begin
                is_put = 1'b1;
                w_byte = r_rd_vld ? r_rd_data : CH_SPACE;
            end
            OP_SPACE: begin
                is_put = 1'b1;
                w_byte = CH_SPACE;
            end
            OP_PUT_C3: begin
                is_put = 1'b1;
                w_byte = CH_LEAD;
            end
            OP_PUT_C7: begin
                is_put = 1'b1;
                w_byte = CH_CCED;
            end
            OP_CMD_80: begin
                w_rs   = 1'b0;
                w_byte = CMD_ROW1;
            end
            OP_CMD_C0: begin
                w_rs   = 1'b0;
                w_byte = CMD_ROW2;
            end
            OP_CR: begin
                w_rs   = 1'b0;
                w_byte = r_row2 ? CMD_ROW2 : CMD_ROW1;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
        do_store = is_put && r_row2 && (r_col < COL_LIMIT);
        produce  = (emit && r_half_vld) || (uw.fin && (emit || r_half_vld));
    end

    // The replay loop reads one entry ahead of the write it issues.
    always_comb begin
        n_idx   = (r_idx == IDX_LAST) ? '0 : r_idx + 1'b1;
        rd_addr = (uw.op == OP_CMD_80) ? '0 : n_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_pc       <= '0;
            r_idx      <= '0;
            r_row2     <= 1'b0;
            r_col      <= '0;
            r_pend     <= 1'b0;
            r_mem_vld  <= '0;
            r_half_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_char_valid && !r_busy) begin
                r_busy <= 1'b1;
                r_pc   <= '0;
            end else if (go) begin
                r_pc <= n_pc;
                if (uw.fin) begin
                    r_busy <= 1'b0;
                end
            end

            if (go) begin
                case (uw.op)
                    OP_CMD_80: begin
                        r_row2 <= 1'b0;
                        r_idx  <= '0;
                    end
                    OP_CMD_C0: begin
                        r_row2 <= 1'b1;
                        r_col  <= '0;
                        r_idx  <= '0;
                    end
                    OP_CR: begin
                        r_col <= '0;
                    end
                    OP_SET_PEND: begin
                        r_pend <= 1'b1;
                    end
                    OP_PUT_C3, OP_PUT_C7: begin
                        r_pend <= 1'b0;
                    end
                    OP_COPY, OP_SPACE: begin
                        r_idx <= n_idx;
                    end
                    default: begin
                    end
                endcase
                if (is_put && r_col != COL_MAX) begin
                    r_col <= r_col + 1'b1;
                end
                if (do_store) begin
                    r_mem_vld[r_col[AW-1:0]] <= 1'b1;
                end

                if (produce) begin
                    r_half_vld <= 1'b0;
                end else if (emit) begin
                    r_half_vld <= 1'b1;
                end
            end

            if (go && produce) begin
                r_out_vld <= 1'b1;
            end else if (i_res_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Memory and payload registers.
    always_ff @(posedge i_clk) begin
        if (i_char_valid && !r_busy) begin
            r_byte <= i_char_byte;
        end
        if (go) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_vld  <= r_mem_vld[rd_addr];
            if (do_store) begin
                r_mem[r_col[AW-1:0]] <= w_byte;
            end
            if (emit && !r_half_vld) begin
                r_half_rs   <= w_rs;
                r_half_byte <= w_byte;
            end
        end
        if (go && produce) begin
            o_last <= uw.fin;
            if (r_half_vld) begin
                o_first_is_data  <= r_half_rs;
                o_first_byte     <= r_half_byte;
                o_second_valid   <= emit;
                o_second_is_data <= emit ? w_rs : 1'b0;
                o_second_byte    <= emit ? w_byte : 8'h00;
            end else begin
                o_first_is_data  <= w_rs;
                o_first_byte     <= w_byte;
                o_second_valid   <= 1'b0;
                o_second_is_data <= 1'b0;
                o_second_byte    <= 8'h00;
            end
        end
    end

endmodule

`default_nettype wire
